FILE: rtl/core/sorter_beat_pipeline_controller_defines.svh
// Assertion macros for the sorter beat pipeline controller.
// Taken in by the top level; needs a clock named clk and a reset named rst in scope.
`ifndef SORTER_BEAT_PIPELINE_CONTROLLER_DEFINES_SVH
`define SORTER_BEAT_PIPELINE_CONTROLLER_DEFINES_SVH

// Plain clocked property, switched off while reset is held.
`define SBPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define SBPC_ASSERT_IMP(label, cond, prop, msg) \
  `SBPC_ASSERT(label, (cond) |-> (prop), msg)

`endif

FILE: rtl/core/sbpc_pkg.sv
// Shared types, constants and the stage routing function of the sorter beat controller.
// No dependencies; used by the stage cell, the target FIFO and the top level.
package sbpc_pkg;

  localparam int NUM_STAGES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TARGET_W        = 3;
  localparam int MOTOR_W         = 8;
  localparam int SLIDE_W         = 16;
  localparam int STATE_W         = 3;
  localparam int CFG_INDEX_W     = 2;
  localparam int CFG_DATA_W      = 16;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_DIR_INVERT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_LEFT_POS   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SLIDE_WAIT = 2'd2;

  localparam logic [MOTOR_W-1:0] DIR_INVERT_RST = 8'h03;
  localparam logic               LEFT_POS_RST   = 1'b0;
  localparam logic [SLIDE_W-1:0] SLIDE_WAIT_RST = 16'd500;

  // Bin identifiers that the routing rules single out.
  localparam logic [TARGET_W-1:0] BIN_EMPTY = 3'd0;
  localparam logic [TARGET_W-1:0] BIN_ONE   = 3'd1;
  localparam logic [TARGET_W-1:0] BIN_TWO   = 3'd2;
  localparam logic [TARGET_W-1:0] BIN_THREE = 3'd3;

  typedef enum logic [1:0] {
    ROT_NONE,
    ROT_LEFT,
    ROT_RIGHT
  } rot_t;

  // Per-transaction commands broadcast along the cell row.
  typedef struct packed {
    logic flush;      // clear the stage target
    logic beat;       // shift in the neighbour's target and relatch enable/direction
    logic home_init;  // first homing step: enable all, clear direction and done
    logic home_step;  // homing step: mask motors whose switch reads low
    logic left_pos;   // a left rotation is a positive move
  } cell_ctrl_t;

  // Only the first three stages have a gate that can rotate.
  function automatic rot_t route_target(input int stage, input logic [TARGET_W-1:0] t);
    rot_t r;
    r = ROT_NONE;
    if (t != BIN_EMPTY) begin
      case (stage)
        0: r = (t == BIN_ONE) ? ROT_LEFT : ROT_RIGHT;
        1: begin
          if (t == BIN_ONE) r = ROT_NONE;
          else r = (t == BIN_TWO) ? ROT_RIGHT : ROT_LEFT;
        end
        2: begin
          if (t == BIN_ONE || t == BIN_TWO) r = ROT_NONE;
          else r = (t == BIN_THREE) ? ROT_LEFT : ROT_RIGHT;
        end
        default: r = ROT_NONE;
      endcase
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/sbpc_target_fifo.sv
// Circular queue of target bins with a registered head read and write bypass.
// Depends on sbpc_pkg.
module sbpc_target_fifo import sbpc_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                push_req,
  input  logic [TARGET_W-1:0] push_data,
  input  logic                flush,
  input  logic                pop,
  output logic                full,
  output logic                avail,
  output logic [TARGET_W-1:0] pop_data
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [TARGET_W-1:0] mem [QUEUE_DEPTH];
  logic [TARGET_W-1:0] head;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [CNT_W-1:0]    count, count_next;
  logic [SUM_W-1:0]    wr_sum;
  logic [PTR_W-1:0]    wr_addr;
  logic                do_write;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign do_write = en && push_req && !full;
  assign avail    = (count != '0) || (push_req && !full);
  // An empty queue hands straight through the item written in the same transaction.
  assign pop_data = (count == '0) ? push_data : head;

  assign wr_sum  = SUM_W'(rd_ptr) + SUM_W'(count);
  assign wr_addr = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? PTR_W'(wr_sum - SUM_W'(QUEUE_DEPTH))
                                                   : PTR_W'(wr_sum);

  always_comb begin
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (en) begin
      if (flush) begin
        rd_ptr_next = '0;
        count_next  = '0;
      end else begin
        count_next = count + CNT_W'(do_write);
        if (pop) begin
          count_next  = count_next - CNT_W'(1);
          rd_ptr_next = (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[wr_addr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    head <= (do_write && wr_addr == rd_ptr_next) ? push_data : mem[rd_ptr_next];
  end

endmodule

FILE: rtl/core/sbpc_stage_cell.sv
// One pipeline stage and its motor: target slot, enable, direction and homing-done bits.
// Depends on sbpc_pkg.
module sbpc_stage_cell import sbpc_pkg::*; #(
  parameter int STAGE_INDEX = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  cell_ctrl_t          ctrl,
  input  logic [TARGET_W-1:0] target_in,
  input  logic                invert,
  input  logic                home_level,
  output logic [TARGET_W-1:0] target,
  output logic                en_next,
  output logic                dir_next,
  output logic                occupied,
  output logic                home_pending
);

  logic                en, dir, done;
  logic                done_next;
  logic [TARGET_W-1:0] target_next;
  logic                done_eff, trigger, pos;
  rot_t                rot;

  assign rot          = route_target(STAGE_INDEX, target_in);
  assign pos          = ((rot == ROT_LEFT) ? ctrl.left_pos : !ctrl.left_pos) ^ invert;
  assign done_eff     = ctrl.home_init ? 1'b0 : done;
  assign trigger      = !done_eff && !home_level;
  assign home_pending = !done_eff && home_level;
  assign occupied     = (target != BIN_EMPTY);

  always_comb begin
    target_next = target;
    en_next     = en;
    dir_next    = dir;
    done_next   = done;
    if (ctrl.flush) begin
      target_next = BIN_EMPTY;
    end else if (ctrl.beat) begin
      target_next = target_in;
    end
    if (ctrl.beat) begin
      en_next  = (rot != ROT_NONE);
      dir_next = (rot != ROT_NONE) && pos;
    end else if (ctrl.home_step) begin
      en_next   = trigger ? 1'b0 : (ctrl.home_init ? 1'b1 : en);
      dir_next  = ctrl.home_init ? 1'b0 : dir;
      done_next = done_eff || trigger;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= BIN_EMPTY;
      en     <= 1'b0;
      dir    <= 1'b0;
      done   <= 1'b0;
    end else begin
      target <= target_next;
      en     <= en_next;
      dir    <= dir_next;
      done   <= done_next;
    end
  end

endmodule

FILE: rtl/core/sorter_beat_pipeline_controller.sv
// Top level of the sorter beat pipeline controller: beat sequencer, row of stage cells,
// target FIFO and output skid pair. Depends on sbpc_pkg, sbpc_target_fifo, sbpc_stage_cell.
//
//   channel  handshake               payload
//   in       in_valid / in_stall     push_valid push_target homing_request stepper_running
//                                    home_switches ms_tick
//   out      out_valid / out_stall   enable_mask dir_bits start_move run_homing_speed
//                                    zero_position stop_motion beat_state push_dropped
//   cfg      cfg_we                  cfg_index cfg_data
//
// Every input transaction is processed in the cycle in which it is accepted, so one
// transaction per clock is sustained while in_stall is low; the cell row and the beat
// sequencer compute their next state combinationally. The result is registered in the
// output register, or in the skid register if that is stalled. Reset needs no clearing
// pass; the queue storage is never read before it has been written. in_stall is a flop:
// it is high only while the skid register holds a result behind a stalled output register.
`include "sorter_beat_pipeline_controller_defines.svh"

module sorter_beat_pipeline_controller import sbpc_pkg::*; #(
  parameter int NUM_STAGES  = NUM_STAGES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   push_valid,
  input  logic [TARGET_W-1:0]    push_target,
  input  logic                   homing_request,
  input  logic                   stepper_running,
  input  logic [MOTOR_W-1:0]     home_switches,
  input  logic                   ms_tick,
  // output channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [MOTOR_W-1:0]     enable_mask,
  output logic [MOTOR_W-1:0]     dir_bits,
  output logic                   start_move,
  output logic                   run_homing_speed,
  output logic                   zero_position,
  output logic                   stop_motion,
  output logic [STATE_W-1:0]     beat_state,
  output logic                   push_dropped
);

  // Beat sequencer states; the homing state is also the default arm.
  localparam logic [STATE_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [STATE_W-1:0] ST_PREP    = 3'd1;
  localparam logic [STATE_W-1:0] ST_MOVING  = 3'd2;
  localparam logic [STATE_W-1:0] ST_SLIDING = 3'd3;
  localparam logic [STATE_W-1:0] ST_DONE    = 3'd4;
  localparam logic [STATE_W-1:0] ST_HOMING  = 3'd5;

  typedef struct packed {
    logic [MOTOR_W-1:0] enable_mask;
    logic [MOTOR_W-1:0] dir_bits;
    logic               start_move;
    logic               run_homing_speed;
    logic               zero_position;
    logic               stop_motion;
    logic [STATE_W-1:0] beat_state;
    logic               push_dropped;
  } result_t;

  // Configuration registers, to be written only while the block is quiet; not enforced.
  logic [MOTOR_W-1:0] dir_invert_mask;
  logic               left_is_positive;
  logic [SLIDE_W-1:0] slide_wait_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      dir_invert_mask  <= DIR_INVERT_RST;
      left_is_positive <= LEFT_POS_RST;
      slide_wait_limit <= SLIDE_WAIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DIR_INVERT: dir_invert_mask  <= cfg_data[MOTOR_W-1:0];
        CFG_LEFT_POS:   left_is_positive <= cfg_data[0];
        CFG_SLIDE_WAIT: slide_wait_limit <= cfg_data[SLIDE_W-1:0];
        default: ;
      endcase
    end
  end

  logic accept;
  assign accept = in_valid && !in_stall;

  // Sequencer registers.
  logic [STATE_W-1:0] state, state_next;
  logic [SLIDE_W-1:0] wait_counter, wait_counter_next, wait_inc;
  logic               homing_started, homing_started_next;

  // FIFO interface.
  logic                fifo_full, fifo_avail, fifo_pop;
  logic [TARGET_W-1:0] fifo_data;

  // Cell row.
  cell_ctrl_t            ctrl;
  logic [TARGET_W-1:0]   stage_tgt [NUM_STAGES];
  logic [NUM_STAGES-1:0] en_vec, dir_vec, occ_vec, pend_vec;
  logic [TARGET_W-1:0]   head_target;

  logic    eff_homing;
  logic    start_c, run_homing_c, zero_c, stop_c;
  result_t result, out_reg, skid_reg;
  logic    skid_valid;

  // A homing request overrides the current state for this transaction.
  assign eff_homing = homing_request || (state != ST_IDLE && state != ST_PREP &&
                      state != ST_MOVING && state != ST_SLIDING && state != ST_DONE);

  assign wait_inc = (ms_tick && wait_counter != '1) ? wait_counter + SLIDE_W'(1) : wait_counter;

  always_comb begin
    state_next          = state;
    wait_counter_next   = wait_counter;
    homing_started_next = homing_started;
    ctrl                = '0;
    ctrl.left_pos       = left_is_positive;
    ctrl.flush          = accept && homing_request;
    fifo_pop            = 1'b0;
    start_c             = 1'b0;
    run_homing_c        = 1'b0;
    zero_c              = 1'b0;
    stop_c              = 1'b0;
    if (eff_homing) begin
      ctrl.home_step = accept;
      ctrl.home_init = accept && !homing_started;
      if (pend_vec == '0) begin
        stop_c              = 1'b1;
        zero_c              = 1'b1;
        homing_started_next = 1'b0;
        state_next          = ST_IDLE;
      end else begin
        run_homing_c        = 1'b1;
        homing_started_next = 1'b1;
        state_next          = ST_HOMING;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (fifo_avail || occ_vec != '0) state_next = ST_PREP;
        end
        ST_PREP: begin
          ctrl.beat  = accept;
          fifo_pop   = fifo_avail;
          start_c    = (en_vec != '0);
          state_next = ST_MOVING;
        end
        ST_MOVING: begin
          if (!stepper_running) begin
            zero_c            = 1'b1;
            wait_counter_next = '0;
            state_next        = ST_SLIDING;
          end
        end
        ST_SLIDING: begin
          wait_counter_next = wait_inc;
          if (wait_inc >= slide_wait_limit) state_next = ST_DONE;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      wait_counter   <= '0;
      homing_started <= 1'b0;
    end else if (accept) begin
      state          <= state_next;
      wait_counter   <= wait_counter_next;
      homing_started <= homing_started_next;
    end
  end

  sbpc_target_fifo #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .en       (accept),
    .push_req (push_valid),
    .push_data(push_target),
    .flush    (homing_request),
    .pop      (fifo_pop),
    .full     (fifo_full),
    .avail    (fifo_avail),
    .pop_data (fifo_data)
  );

  // Stage 0 takes the queue head, or an empty slot when nothing is queued.
  assign head_target = fifo_avail ? fifo_data : BIN_EMPTY;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_cell
    logic [TARGET_W-1:0] nb_target;
    if (g == 0) begin : g_head
      assign nb_target = head_target;
    end else begin : g_link
      assign nb_target = stage_tgt[g-1];
    end
    sbpc_stage_cell #(
      .STAGE_INDEX(g)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .target_in   (nb_target),
      .invert      (dir_invert_mask[g]),
      .home_level  (home_switches[g]),
      .target      (stage_tgt[g]),
      .en_next     (en_vec[g]),
      .dir_next    (dir_vec[g]),
      .occupied    (occ_vec[g]),
      .home_pending(pend_vec[g])
    );
  end

  always_comb begin
    result.enable_mask      = MOTOR_W'(en_vec);
    result.dir_bits         = MOTOR_W'(dir_vec);
    result.start_move       = start_c;
    result.run_homing_speed = run_homing_c;
    result.zero_position    = zero_c;
    result.stop_motion      = stop_c;
    result.beat_state       = state_next;
    result.push_dropped     = push_valid && fifo_full;
  end

  // Output register with a skid register behind it, so that a stalled result does not
  // block the input side at once: the next result waits in the skid register.
  assign in_stall = skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
      end
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (accept) begin
        out_reg <= result;
      end
    end else if (accept) begin
      skid_reg <= result;
    end
  end

  assign enable_mask      = out_reg.enable_mask;
  assign dir_bits         = out_reg.dir_bits;
  assign start_move       = out_reg.start_move;
  assign run_homing_speed = out_reg.run_homing_speed;
  assign zero_position    = out_reg.zero_position;
  assign stop_motion      = out_reg.stop_motion;
  assign beat_state       = out_reg.beat_state;
  assign push_dropped     = out_reg.push_dropped;

  // The skid register only ever holds a result behind an occupied output register.
  `SBPC_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  // Homing is only marked as started while the sequencer sits in the homing state.
  `SBPC_ASSERT_IMP(a_homing_flag, homing_started, state == ST_HOMING,
                   "homing flag set outside homing")
  // A move command always leaves the sequencer waiting for the stepper.
  `SBPC_ASSERT_IMP(a_move_state, out_valid && start_move, beat_state == ST_MOVING,
                   "move commanded outside the moving state")
  // End of homing declares zero and returns to idle.
  `SBPC_ASSERT_IMP(a_home_end, out_valid && stop_motion,
                   zero_position && beat_state == ST_IDLE, "homing end without zero or idle")

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for sorter_beat_pipeline_controller.
// Holds its own model of the beat sequencer, target FIFO and stage row and checks every
// output transaction; depends only on sbpc_pkg and the controller RTL.
`timescale 1ns / 1ps

module testbench;
  import sbpc_pkg::*;

  // Beat sequencer states, in the encoding that beat_state reports.
  typedef enum logic [STATE_W-1:0] {
    BEAT_IDLE,
    BEAT_PREP,
    BEAT_MOVING,
    BEAT_SLIDING,
    BEAT_DONE,
    BEAT_HOMING
  } beat_state_e;

  // One controller update as it travels on the input channel.
  typedef struct packed {
    logic                push;
    logic [TARGET_W-1:0] bin;
    logic                home_req;
    logic                running;
    logic [MOTOR_W-1:0]  switches;
    logic                tick;
  } ctrl_update_t;

  localparam int UPDATE_W = $bits(ctrl_update_t);

  // One output transaction; field order follows the port list.
  typedef struct packed {
    logic [MOTOR_W-1:0] en_mask;
    logic [MOTOR_W-1:0] dir;
    logic               start;
    logic               homing_speed;
    logic               zero;
    logic               stop;
    logic [STATE_W-1:0] state;
    logic               dropped;
  } beat_outputs_t;

  // Every input of the block has a known value from time zero.
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_DIR_INVERT;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   push_valid = 1'b0;
  logic [TARGET_W-1:0]    push_target = BIN_EMPTY;
  logic                   homing_request = 1'b0;
  logic                   stepper_running = 1'b0;
  logic [MOTOR_W-1:0]     home_switches = '1;
  logic                   ms_tick = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [MOTOR_W-1:0]     enable_mask;
  logic [MOTOR_W-1:0]     dir_bits;
  logic                   start_move;
  logic                   run_homing_speed;
  logic                   zero_position;
  logic                   stop_motion;
  logic [STATE_W-1:0]     beat_state;
  logic                   push_dropped;

  sorter_beat_pipeline_controller u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .push_valid      (push_valid),
    .push_target     (push_target),
    .homing_request  (homing_request),
    .stepper_running (stepper_running),
    .home_switches   (home_switches),
    .ms_tick         (ms_tick),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .enable_mask     (enable_mask),
    .dir_bits        (dir_bits),
    .start_move      (start_move),
    .run_homing_speed(run_homing_speed),
    .zero_position   (zero_position),
    .stop_motion     (stop_motion),
    .beat_state      (beat_state),
    .push_dropped    (push_dropped)
  );

  // Model state: a private copy of the controller, advanced once per accepted transaction.
  logic [TARGET_W-1:0] bin_fifo [QUEUE_DEPTH_DEF];
  int unsigned         fifo_rd = 0;
  int unsigned         fifo_cnt = 0;
  logic [TARGET_W-1:0] stage_bin [NUM_STAGES_DEF] = '{default: BIN_EMPTY};
  beat_state_e         beat_st = BEAT_IDLE;
  int unsigned         slide_cnt = 0;
  logic                homing_active = 1'b0;
  logic [MOTOR_W-1:0]  homed_mask = '0;
  logic [MOTOR_W-1:0]  en_latch = '0;
  logic [MOTOR_W-1:0]  dir_latch = '0;

  // Model copy of the configuration registers, starting from their reset values.
  logic [MOTOR_W-1:0]  cfg_invert = DIR_INVERT_RST;
  logic                cfg_left_pos = LEFT_POS_RST;
  logic [SLIDE_W-1:0]  cfg_slide_wait = SLIDE_WAIT_RST;

  // Outputs still owed by the block, oldest first.
  beat_outputs_t awaited_outputs [$];
  int            fail_count = 0;

  // Pacing of both channels. gap_max of zero means the sender never idles. The receiver
  // either follows stall_mode or, while hold_left runs down, holds off completely.
  int gap_max = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int hold_request = 0;
  int hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Advances the model by one update and returns the outputs that it should produce.
  // The push is taken first, so a homing request in the same update flushes it too.
  function automatic beat_outputs_t advance_controller(input ctrl_update_t u);
    beat_outputs_t      r;
    logic [MOTOR_W-1:0] en;
    logic [MOTOR_W-1:0] dir;
    logic               busy_pipe;
    logic               all_home;
    logic               positive;
    rot_t               turn;
    r = '0;
    if (u.push) begin
      if (fifo_cnt >= QUEUE_DEPTH_DEF) begin
        r.dropped = 1'b1;
      end else begin
        bin_fifo[(fifo_rd + fifo_cnt) % QUEUE_DEPTH_DEF] = u.bin;
        fifo_cnt++;
      end
    end
    if (u.home_req) begin
      fifo_cnt = 0;
      fifo_rd = 0;
      foreach (stage_bin[i]) stage_bin[i] = BIN_EMPTY;
      beat_st = BEAT_HOMING;
    end
    case (beat_st)
      BEAT_IDLE: begin
        busy_pipe = 1'b0;
        foreach (stage_bin[i]) if (stage_bin[i] != BIN_EMPTY) busy_pipe = 1'b1;
        if (fifo_cnt != 0 || busy_pipe) beat_st = BEAT_PREP;
      end
      BEAT_PREP: begin
        // New beat: everything moves one stage downstream and stage 0 takes the FIFO head.
        for (int i = NUM_STAGES_DEF - 1; i > 0; i--) stage_bin[i] = stage_bin[i-1];
        if (fifo_cnt != 0) begin
          stage_bin[0] = bin_fifo[fifo_rd];
          fifo_rd = (fifo_rd + 1) % QUEUE_DEPTH_DEF;
          fifo_cnt--;
        end else begin
          stage_bin[0] = BIN_EMPTY;
        end
        en = '0;
        dir = '0;
        for (int i = 0; i < NUM_STAGES_DEF; i++) begin
          // Gate rules: stage 0 sends bin 1 left, stage 1 catches bins 2 and up, stage 2
          // bins 3 and up; later stages and empty slots stay put.
          turn = ROT_NONE;
          case (i)
            0: if (stage_bin[i] != BIN_EMPTY)
                 turn = (stage_bin[i] == BIN_ONE) ? ROT_LEFT : ROT_RIGHT;
            1: if (stage_bin[i] > BIN_ONE)
                 turn = (stage_bin[i] == BIN_TWO) ? ROT_RIGHT : ROT_LEFT;
            2: if (stage_bin[i] > BIN_TWO)
                 turn = (stage_bin[i] == BIN_THREE) ? ROT_LEFT : ROT_RIGHT;
            default: turn = ROT_NONE;
          endcase
          if (turn != ROT_NONE) begin
            positive = (turn == ROT_LEFT) ? cfg_left_pos : !cfg_left_pos;
            positive ^= cfg_invert[i];
            en[i] = 1'b1;
            dir[i] = positive;
          end
        end
        en_latch = en;
        dir_latch = dir;
        r.start = |en;
        beat_st = BEAT_MOVING;
      end
      BEAT_MOVING: begin
        if (!u.running) begin
          r.zero = 1'b1;
          slide_cnt = 0;
          beat_st = BEAT_SLIDING;
        end
      end
      BEAT_SLIDING: begin
        if (u.tick && slide_cnt < 65535) slide_cnt++;
        if (slide_cnt >= cfg_slide_wait) beat_st = BEAT_DONE;
      end
      BEAT_DONE: beat_st = BEAT_IDLE;
      default: begin
        // Homing: all motors run until their switch reads low; a repeated request
        // keeps the motors already found.
        if (!homing_active) begin
          homed_mask = '0;
          dir_latch = '0;
          en_latch = '1;
          homing_active = 1'b1;
        end
        all_home = 1'b1;
        for (int i = 0; i < NUM_STAGES_DEF; i++) begin
          if (!homed_mask[i]) begin
            if (!u.switches[i]) begin
              en_latch[i] = 1'b0;
              homed_mask[i] = 1'b1;
            end else begin
              all_home = 1'b0;
            end
          end
        end
        if (all_home) begin
          r.stop = 1'b1;
          r.zero = 1'b1;
          homing_active = 1'b0;
          beat_st = BEAT_IDLE;
        end else begin
          r.homing_speed = 1'b1;
        end
      end
    endcase
    r.en_mask = en_latch;
    r.dir = dir_latch;
    r.state = beat_st;
    return r;
  endfunction

  // Offers one update and waits for the handshake. Bursts of random length are separated
  // by random gaps when gap_max is non-zero. The payload is held while stalled.
  task automatic send_update(input ctrl_update_t u);
    if (gap_max != 0 && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    push_valid <= u.push;
    push_target <= u.bin;
    homing_request <= u.home_req;
    stepper_running <= u.running;
    home_switches <= u.switches;
    ms_tick <= u.tick;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_outputs.push_back(advance_controller(u));
    if (burst_left != 0) burst_left--;
  endtask

  // Stops offering and waits until every owed transaction has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(posedge clk);
  endtask

  // Writes all three registers one after another once the block has gone quiet.
  task automatic set_config(input logic [MOTOR_W-1:0] invert, input logic left_pos,
                            input logic [SLIDE_W-1:0] wait_ms);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_index <= CFG_DIR_INVERT;
    cfg_data <= CFG_DATA_W'(invert);
    @(posedge clk);
    cfg_index <= CFG_LEFT_POS;
    cfg_data <= CFG_DATA_W'(left_pos);
    @(posedge clk);
    cfg_index <= CFG_SLIDE_WAIT;
    cfg_data <= wait_ms;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_invert = invert;
    cfg_left_pos = left_pos;
    cfg_slide_wait = wait_ms;
  endtask

  // Keeps the stepper running so the first beat never finishes and the FIFO fills until a
  // push is refused. Every bin id goes in. A final push coincides with a homing request
  // and all switches low, so the push is flushed and homing ends at once.
  task automatic test_queue_overflow();
    ctrl_update_t u;
    gap_max = 0;
    stall_mode = 0;
    for (int k = 0; k < 18; k++) begin
      u.push = 1'b1;
      u.bin = TARGET_W'(k);
      u.home_req = 1'b0;
      u.running = 1'b1;
      u.switches = MOTOR_W'($urandom);
      u.tick = k[0];
      send_update(u);
    end
    u.home_req = 1'b1;
    u.bin = 3'd7;
    u.switches = 8'h00;
    send_update(u);
  endtask

  // A second homing request part-way through homing must keep the motors already found.
  task automatic test_homing_restart();
    ctrl_update_t u;
    u = '0;
    u.home_req = 1'b1;
    u.switches = 8'hFE;
    u.tick = 1'b1;
    send_update(u);
    u.switches = 8'hFF;
    u.running = 1'b1;
    send_update(u);
    u.home_req = 1'b0;
    u.switches = 8'h7F;
    send_update(u);
    u.switches = 8'h00;
    send_update(u);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering, so the
  // skid pair fills and the input channel is stalled.
  task automatic test_output_hold_off();
    ctrl_update_t u;
    gap_max = 0;
    stall_mode = 0;
    hold_request = 300;
    for (int k = 0; k < 40; k++) begin
      u = UPDATE_W'($urandom);
      u.home_req = 1'b0;
      u.tick = 1'b1;
      send_update(u);
    end
  endtask

  // Mostly well-formed traffic: the stepper stops soon after a move, ticks are frequent and
  // switches drop out now and then; only the stepper follows the model's state. About
  // one transaction in ten is pure noise. Pacing and push rate change every hundred.
  task automatic test_random_traffic(input int n_items);
    ctrl_update_t u;
    int           push_pct;
    push_pct = 50;
    for (int n = 0; n < n_items; n++) begin
      if (n % 100 == 0) begin
        case ($urandom_range(0, 3))
          0: gap_max = 0;
          1: gap_max = 2;
          2: gap_max = 5;
          default: gap_max = 10;
        endcase
        stall_mode = $urandom_range(0, 3);
        case ($urandom_range(0, 2))
          0: push_pct = 10;
          1: push_pct = 40;
          default: push_pct = 90;
        endcase
      end
      if ($urandom_range(0, 9) == 0) begin
        u = UPDATE_W'($urandom);
      end else begin
        u.push = ($urandom_range(0, 99) < push_pct);
        u.bin = TARGET_W'($urandom_range(0, 7));
        u.home_req = ($urandom_range(0, 99) == 0);
        u.running = (beat_st == BEAT_MOVING) ? ($urandom_range(0, 2) != 0)
                                             : ($urandom_range(0, 1) != 0);
        u.switches = MOTOR_W'($urandom | $urandom);
        u.tick = ($urandom_range(0, 3) != 0);
      end
      send_update(u);
    end
  endtask

  // A long slide wait: the counter has to climb a few hundred ticks before the beat
  // completes. Run flat out; all switches read low so that any homing left over ends
  // at once, and the stepper is idle so the sequencer soon reaches the sliding wait.
  task automatic test_long_slide_wait();
    ctrl_update_t u;
    set_config(8'hA5, 1'b0, 16'd300);
    gap_max = 0;
    stall_mode = 0;
    u = '0;
    u.push = 1'b1;
    u.bin = BIN_THREE;
    send_update(u);
    u.push = 1'b0;
    u.tick = 1'b1;
    while (beat_st != BEAT_SLIDING) send_update(u);
    while (beat_st == BEAT_SLIDING) send_update(u);
  endtask

  // Receiver: a long hold-off when one is requested, otherwise the current stall pattern.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left <= hold_request;
      hold_request = 0;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 7) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ($urandom_range(0, 15) == 0) ? !out_stall : out_stall;
      endcase
    end
  end

  // Every output transaction is matched against the oldest owed result.
  always @(posedge clk) begin : check_outputs
    beat_outputs_t got;
    beat_outputs_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {enable_mask, dir_bits, start_move, run_homing_speed, zero_position,
             stop_motion, beat_state, push_dropped};
      if (awaited_outputs.size() == 0) begin
        if (fail_count < 10) $display("%0t: output transaction with none owed", $realtime);
        fail_count++;
      end else begin
        want = awaited_outputs.pop_front();
        if (got !== want) begin
          if (fail_count < 10) begin
            $display("%0t: mismatch en/dir/start/hs/zero/stop/state/drop", $realtime);
            $display("  exp %h %h %b %b %b %b %0d %b", want.en_mask, want.dir, want.start,
                     want.homing_speed, want.zero, want.stop, want.state, want.dropped);
            $display("  got %h %h %b %b %b %b %0d %b", got.en_mask, got.dir, got.start,
                     got.homing_speed, got.zero, got.stop, got.state, got.dropped);
          end
          fail_count++;
        end
      end
    end
  end

  // Main sequence: directed cases under the reset configuration, then random traffic
  // under a series of settings including both extremes, then a long slide wait.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_queue_overflow();
    test_homing_restart();
    test_output_hold_off();
    set_config(8'h00, 1'b0, 16'd0);
    test_random_traffic(200);
    set_config(8'hFF, 1'b1, 16'd1);
    test_random_traffic(200);
    repeat (4) begin
      set_config(MOTOR_W'($urandom), 1'($urandom_range(0, 1)),
                 SLIDE_W'($urandom_range(0, 6)));
      test_random_traffic(200);
    end
    test_long_slide_wait();
    wait_for_results();
    // A short tail after the last owed result catches anything extra.
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sorter_beat_pipeline_controller: PASSED **");
    end else begin
      $display("** sorter_beat_pipeline_controller: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("** sorter_beat_pipeline_controller: FAILED **");
    $finish;
  end

endmodule
